// ===== src/vdp_pkg.sv =====
package vdp_pkg;

	localparam int POOL_DEPTH = 4096;
	localparam int IDX_W      = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int COORD_W    = 32;
	localparam int TOL_W      = 31;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int ACT_W      = 2;
	localparam int STS_W      = 2;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

	localparam logic [ACT_W-1:0] ACT_FIND  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL      = 2'd2;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic exec;
		logic issue;
		logic set_hit;
		logic set_miss;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_find;
		logic cnt_nonzero;
		logic match;
		logic issue_done;
		logic pipe_busy;
		logic out_free;
	} stat_t;

endpackage

// ===== src/vdp_ifs.sv =====
interface vdp_req_if;
	logic                               valid;
	logic                               ready;
	logic [vdp_pkg::ACT_W-1:0]          action;
	logic signed [vdp_pkg::COORD_W-1:0] coord_x;
	logic signed [vdp_pkg::COORD_W-1:0] coord_y;
	logic signed [vdp_pkg::COORD_W-1:0] coord_z;

	modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

interface vdp_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [vdp_pkg::STS_W-1:0] status;
	logic [vdp_pkg::IDX_W-1:0] entry_index;
	logic [vdp_pkg::CNT_W-1:0] fill_count;

	modport source (output valid, status, entry_index, fill_count, input ready);
	modport sink (input valid, status, entry_index, fill_count, output ready);
endinterface

interface vdp_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [vdp_pkg::TOL_W-1:0] match_tolerance;

	modport source (output valid, match_tolerance, input ready);
	modport sink (input valid, match_tolerance, output ready);
endinterface

// ===== src/vdp_ctrl.sv =====
module vdp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  vdp_pkg::stat_t stat,
	output vdp_pkg::cmd_t  cmd
);
	import vdp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_DISPATCH = 4'b0010,
		S_SCAN     = 4'b0100,
		S_RESP     = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_find && stat.cnt_nonzero) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_RESP;
				end
			end
			S_SCAN: begin
				if (stat.match) begin
					cmd.set_hit = 1'b1;
					state_d     = S_RESP;
				end else if (stat.issue_done && !stat.pipe_busy) begin
					cmd.set_miss = 1'b1;
					state_d      = S_RESP;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/vdp_datapath.sv =====
module vdp_datapath (
	input  logic          clk,
	input  logic          arst_n,
	vdp_req_if.sink       req,
	vdp_rsp_if.source     rsp,
	vdp_cfg_if.sink       cfg,
	input  vdp_pkg::cmd_t cmd,
	output vdp_pkg::stat_t stat
);
	import vdp_pkg::*;

	localparam int VTX_W = 3 * COORD_W;

	logic [VTX_W-1:0] vtx_mem [POOL_DEPTH];

	logic [TOL_W-1:0]         tol_q;
	logic signed [DIFF_W-1:0] neg_tol_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         scan_q;
	logic [ACT_W-1:0]         act_q;
	logic [VTX_W-1:0]         query_q;
	logic [STS_W-1:0]         res_status_q;
	logic [IDX_W-1:0]         res_index_q;

	logic                     valid_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [VTX_W-1:0]         rd_data_s1;
	logic                     valid_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [DIFF_W-1:0] dx_s2;
	logic signed [DIFF_W-1:0] dy_s2;
	logic signed [DIFF_W-1:0] dz_s2;

	logic                     out_valid_q;
	logic [STS_W-1:0]         out_status_q;
	logic [IDX_W-1:0]         out_index_q;
	logic [CNT_W-1:0]         out_fill_q;

	logic                     issue_ok;
	logic signed [DIFF_W-1:0] pos_tol;
	logic                     close_x;
	logic                     close_y;
	logic                     close_z;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= TOL_RESET;
			neg_tol_q <= -$signed({2'b00, TOL_RESET});
		end else if (cfg.valid) begin
			tol_q     <= cfg.match_tolerance;
			neg_tol_q <= -$signed({2'b00, cfg.match_tolerance});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= req.action;
			query_q <= {req.coord_x, req.coord_y, req.coord_z};
		end
	end

	assign issue_ok = cmd.issue && (scan_q != cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.exec && (act_q == ACT_ADD) && (cnt_q != CNT_W'(POOL_DEPTH))) begin
			vtx_mem[cnt_q[IDX_W-1:0]] <= query_q;
		end
		rd_data_s1 <= vtx_mem[scan_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			scan_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (act_q == ACT_ADD && cnt_q != CNT_W'(POOL_DEPTH)) begin
					cnt_q <= CNT_W'(cnt_q + 1'b1);
				end else if (act_q == ACT_CLEAR) begin
					cnt_q <= '0;
				end
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
			end else if (issue_ok) begin
				scan_q <= CNT_W'(scan_q + 1'b1);
			end
			if (cmd.set_hit || cmd.set_miss) begin
				valid_s1 <= 1'b0;
				valid_s2 <= 1'b0;
			end else begin
				valid_s1 <= issue_ok;
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		dx_s2  <= $signed({query_q[3*COORD_W-1], query_q[3*COORD_W-1:2*COORD_W]})
		        - $signed({rd_data_s1[3*COORD_W-1], rd_data_s1[3*COORD_W-1:2*COORD_W]});
		dy_s2  <= $signed({query_q[2*COORD_W-1], query_q[2*COORD_W-1:COORD_W]})
		        - $signed({rd_data_s1[2*COORD_W-1], rd_data_s1[2*COORD_W-1:COORD_W]});
		dz_s2  <= $signed({query_q[COORD_W-1], query_q[COORD_W-1:0]})
		        - $signed({rd_data_s1[COORD_W-1], rd_data_s1[COORD_W-1:0]});
	end

	assign pos_tol = $signed({2'b00, tol_q});
	assign close_x = (dx_s2 < pos_tol) && (dx_s2 > neg_tol_q);
	assign close_y = (dy_s2 < pos_tol) && (dy_s2 > neg_tol_q);
	assign close_z = (dz_s2 < pos_tol) && (dz_s2 > neg_tol_q);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_index_q <= '0;
			case (act_q)
				ACT_FIND: begin
					res_status_q <= STS_NOT_FOUND;
				end
				ACT_ADD: begin
					if (cnt_q != CNT_W'(POOL_DEPTH)) begin
						res_status_q <= STS_OK;
						res_index_q  <= cnt_q[IDX_W-1:0];
					end else begin
						res_status_q <= STS_FULL;
					end
				end
				default: begin
					res_status_q <= STS_OK;
				end
			endcase
		end else if (cmd.set_hit) begin
			res_status_q <= STS_OK;
			res_index_q  <= idx_s2;
		end else if (cmd.set_miss) begin
			res_status_q <= STS_NOT_FOUND;
			res_index_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_fill_q   <= cnt_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_index = out_index_q;
	assign rsp.fill_count  = out_fill_q;

	assign stat.is_find     = (act_q == ACT_FIND);
	assign stat.cnt_nonzero = (cnt_q != '0);
	assign stat.match       = valid_s2 && close_x && close_y && close_z;
	assign stat.issue_done  = (scan_q == cnt_q);
	assign stat.pipe_busy   = valid_s1 || valid_s2;
	assign stat.out_free    = !out_valid_q || rsp.ready;

endmodule

// ===== src/vertex_dedup_pool_top.sv =====
// Vertex pool with tolerance matching.
// The req channel carries one item per action: find, add or clear, with the
// vertex coordinates in signed Q16.16. The rsp channel returns exactly one item
// per request with a status, the entry index and the fill count after the action.
// The cfg channel writes the per-axis match tolerance; it is always ready and
// should be written only while no request is outstanding.
// Add, clear, the unused action code and a find on an empty table go from the
// dispatch state straight to the response state. A find scans stored entries in
// insertion order, one entry per cycle through the single read port of the vertex
// memory, and responds on the first match or, on a miss, once the whole fill
// count has been scanned.
// The block accepts the next request as soon as the response is in the output
// register, so a stalled receiver holds that one response while the next item
// is already being processed; it is then held back before its own response.
// Reset empties the table and sets the tolerance to 66; the vertex memory
// itself is not cleared and needs no pass after reset.
module vertex_dedup_pool_top (
	input  logic      clk,
	input  logic      arst_n,
	vdp_req_if.sink   req,
	vdp_rsp_if.source rsp,
	vdp_cfg_if.sink   cfg
);
	import vdp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	vdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vdp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

// ===== src/vdp_checker.sv =====
module vdp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [vdp_pkg::STS_W-1:0] rsp_status,
	input logic [vdp_pkg::IDX_W-1:0] rsp_entry_index,
	input logic [vdp_pkg::CNT_W-1:0] rsp_fill_count
);
	import vdp_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_entry_index) && $stable(rsp_fill_count))
		else $error("Stalled response item changed.");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STS_FULL |->
			rsp_fill_count == CNT_W'(POOL_DEPTH) && rsp_entry_index == '0)
		else $error("Dropped add reported with a table that is not full.");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STS_NOT_FOUND |-> rsp_entry_index == '0)
		else $error("Miss reported with a nonzero index.");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STS_OK && rsp_fill_count != '0 |->
			CNT_W'(rsp_entry_index) < rsp_fill_count)
		else $error("Entry index beyond the fill count.");

endmodule

bind vertex_dedup_pool_top vdp_checker u_vdp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_index (rsp.entry_index),
	.rsp_fill_count  (rsp.fill_count)
);
